// ===== design/pboc_pkg.sv =====
// shared constants and register codes for the pose bin occupancy counter
package pboc_pkg;

	// fixed field widths
	localparam int POS_W      = 16;
	localparam int HEAD_W     = 16;
	localparam int CELLS_W    = 7;
	localparam int COUNT_W    = 18;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// bitmap memory word
	localparam int WORD_W = 32;

	localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;
	localparam logic [CELLS_W-1:0] CELLS_RESET = 7'd64;

	// item kinds
	localparam logic KIND_ADD   = 1'b0;
	localparam logic KIND_CLEAR = 1'b1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_X_ORIGIN       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_Y_ORIGIN       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HEADING_ORIGIN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_X_CELLS_USED   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_Y_CELLS_USED   = 3'd4;

	// parameter defaults
	localparam int DEF_MAX_X_CELLS   = 64;
	localparam int DEF_MAX_Y_CELLS   = 64;
	localparam int DEF_HEADING_CELLS = 36;
	localparam int DEF_POS_CELL_MM   = 100;

endpackage

// ===== design/pose_bin_occupancy_counter.sv =====
// pose bin occupancy counter: quantizes poses into 3-d bins held in a bitmap memory
// a pose gives its result strobe after the pipeline stages and the result register; busy stays
//   high until then, so one pose is in flight at a time (set by the bitmap read-modify-write)
// a clear gives its result strobe in the cycle after the start transfer, then busy stays high
//   while the bitmap is swept one 32-bit row a cycle over all DEPTH rows (4608 with defaults)
// reset: registers take their reset values and the same sweep runs; the receiver cannot stall
module pose_bin_occupancy_counter
	import pboc_pkg::*;
#(
	parameter int MAX_X_CELLS   = DEF_MAX_X_CELLS,
	parameter int MAX_Y_CELLS   = DEF_MAX_Y_CELLS,
	parameter int HEADING_CELLS = DEF_HEADING_CELLS,
	parameter int POS_CELL_MM   = DEF_POS_CELL_MM
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// configuration writes
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	// item command
	input  logic                    start,
	output logic                    busy,
	input  logic                    kind,
	input  logic signed [POS_W-1:0] x_pos,
	input  logic signed [POS_W-1:0] y_pos,
	input  logic [HEAD_W-1:0]       heading,
	// result
	output logic                    done,
	output logic                    new_bin,
	output logic [COUNT_W-1:0]      occupied_count
);

	// index widths, at least one bit each
	localparam int XIW = (MAX_X_CELLS > 1) ? $clog2(MAX_X_CELLS) : 1;
	localparam int YIW = (MAX_Y_CELLS > 1) ? $clog2(MAX_Y_CELLS) : 1;
	localparam int HIW = (HEADING_CELLS > 1) ? $clog2(HEADING_CELLS) : 1;
	localparam int XY_CELLS = MAX_X_CELLS * MAX_Y_CELLS;
	localparam int XYW = (XY_CELLS > 1) ? $clog2(XY_CELLS) : 1;
	localparam int TOTAL_BINS = XY_CELLS * HEADING_CELLS;

	// bitmap memory geometry
	localparam int DEPTH  = (TOTAL_BINS + WORD_W - 1) / WORD_W;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int WSEL_W = $clog2(WORD_W);
	localparam int BINW   = ADDR_W + WSEL_W;
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

	// floor division by the cell size as a multiply by a rounded-up reciprocal,
	// exact for every 16-bit offset
	localparam int SHX     = POS_W + $clog2(POS_CELL_MM);
	localparam int RECIP_W = POS_W + 1;
	localparam int PROD_W  = POS_W + RECIP_W;
	localparam longint RECIP =
		((longint'(1) << SHX) + longint'(POS_CELL_MM) - 1) / longint'(POS_CELL_MM);
	localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);

	// heading scale
	localparam int HCW = $clog2(HEADING_CELLS + 1);
	localparam int HPW = HEAD_W + HCW;
	localparam logic [HCW-1:0] HC_C = HCW'(HEADING_CELLS);

	// configuration registers
	logic signed [POS_W-1:0] x_origin_q;
	logic signed [POS_W-1:0] y_origin_q;
	logic [HEAD_W-1:0]       heading_origin_q;
	logic [CELLS_W-1:0]      x_cells_q;
	logic [CELLS_W-1:0]      y_cells_q;

	// pipeline valid bits and clear sweep
	logic              v_s1, v_s2, v_s3, v_s4, v_s5;
	logic              clr_q;
	logic [ADDR_W-1:0] clr_addr_q;
	logic [COUNT_W-1:0] count_q;

	// result registers
	logic               done_q;
	logic               new_bin_q;
	logic [COUNT_W-1:0] occ_q;

	// pipeline payload
	logic signed [POS_W:0] dx_s1, dy_s1;
	logic [HEAD_W-1:0]     dh_s1;
	logic [PROD_W-1:0]     px_s2, py_s2;
	logic [HPW-1:0]        ph_s2;
	logic                  negx_s2, negy_s2;
	logic [XYW-1:0]        xy_s3;
	logic [HIW-1:0]        hi_s3;
	logic                  ok_s3;
	logic [BINW-1:0]       bin_s4;
	logic                  ok_s4;
	logic [BINW-1:0]       bin_s5;
	logic                  ok_s5;

	// bitmap memory
	logic [WORD_W-1:0] mem [DEPTH];
	logic [WORD_W-1:0] rd_q;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [WORD_W-1:0] mem_wdata;

	logic accept, accept_add, accept_clr;
	logic [POS_W-1:0] qx, qy, lim_x, lim_y;
	logic ok_x, ok_y;
	logic [WSEL_W-1:0] bit_sel;
	logic is_new;
	logic [COUNT_W-1:0] count_nxt;

	// one item in flight at a time, so no two accesses to a row can overlap
	assign busy       = v_s1 | v_s2 | v_s3 | v_s4 | v_s5 | clr_q;
	assign accept     = start & ~busy;
	assign accept_add = accept & (kind == KIND_ADD);
	assign accept_clr = accept & (kind == KIND_CLEAR);

	// quotient and range check on the stage 2 products
	always_comb begin
		qx    = POS_W'(px_s2 >> SHX);
		qy    = POS_W'(py_s2 >> SHX);
		lim_x = (int'(x_cells_q) > MAX_X_CELLS) ? POS_W'(MAX_X_CELLS) : POS_W'(x_cells_q);
		lim_y = (int'(y_cells_q) > MAX_Y_CELLS) ? POS_W'(MAX_Y_CELLS) : POS_W'(y_cells_q);
		ok_x  = ~negx_s2 & (qx < lim_x);
		ok_y  = ~negy_s2 & (qy < lim_y);
	end

	// read-modify-write of the bin bit in stage 5
	always_comb begin
		bit_sel   = bin_s5[WSEL_W-1:0];
		is_new    = v_s5 & ok_s5 & ~rd_q[bit_sel];
		count_nxt = count_q;
		if (is_new && count_q != COUNT_MAX) begin
			count_nxt = count_q + COUNT_W'(1);
		end
	end

	// memory write port: clear sweep or marking a bin
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = bin_s5[BINW-1:WSEL_W];
		mem_wdata = rd_q | (WORD_W'(1) << bit_sel);
		if (clr_q) begin
			mem_we    = 1'b1;
			mem_waddr = clr_addr_q;
			mem_wdata = '0;
		end else if (is_new) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (v_s4) begin
			rd_q <= mem[bin_s4[BINW-1:WSEL_W]];
		end
	end

	// datapath stages
	always_ff @(posedge clk) begin
		// stage 1: offsets from the origin
		if (accept_add) begin
			dx_s1 <= {x_pos[POS_W-1], x_pos} - {x_origin_q[POS_W-1], x_origin_q};
			dy_s1 <= {y_pos[POS_W-1], y_pos} - {y_origin_q[POS_W-1], y_origin_q};
			dh_s1 <= heading - heading_origin_q;
		end
		// stage 2: reciprocal and heading products
		px_s2   <= dx_s1[POS_W-1:0] * RECIP_C;
		py_s2   <= dy_s1[POS_W-1:0] * RECIP_C;
		ph_s2   <= dh_s1 * HC_C;
		negx_s2 <= dx_s1[POS_W];
		negy_s2 <= dy_s1[POS_W];
		// stage 3: cell indexes and grid check
		xy_s3 <= XYW'(qx[XIW-1:0]) * XYW'(MAX_Y_CELLS) + XYW'(qy[YIW-1:0]);
		hi_s3 <= HIW'(ph_s2 >> HEAD_W);
		ok_s3 <= ok_x & ok_y;
		// stage 4: bin number, row read issued
		bin_s4 <= BINW'(xy_s3) * BINW'(HEADING_CELLS) + BINW'(hi_s3);
		ok_s4  <= ok_s3;
		// stage 5: row data arrives
		bin_s5 <= bin_s4;
		ok_s5  <= ok_s4;
	end

	// control, configuration and results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_origin_q       <= '0;
			y_origin_q       <= '0;
			heading_origin_q <= '0;
			x_cells_q        <= CELLS_RESET;
			y_cells_q        <= CELLS_RESET;
			v_s1             <= 1'b0;
			v_s2             <= 1'b0;
			v_s3             <= 1'b0;
			v_s4             <= 1'b0;
			v_s5             <= 1'b0;
			clr_q            <= 1'b1;
			clr_addr_q       <= '0;
			count_q          <= '0;
			done_q           <= 1'b0;
			new_bin_q        <= 1'b0;
			occ_q            <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_X_ORIGIN:       x_origin_q       <= cfg_data;
					REG_Y_ORIGIN:       y_origin_q       <= cfg_data;
					REG_HEADING_ORIGIN: heading_origin_q <= cfg_data;
					REG_X_CELLS_USED:   x_cells_q        <= cfg_data[CELLS_W-1:0];
					REG_Y_CELLS_USED:   y_cells_q        <= cfg_data[CELLS_W-1:0];
					default: ;
				endcase
			end

			v_s1 <= accept_add;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;

			// clear sweep, one row a cycle
			if (accept_clr) begin
				clr_q      <= 1'b1;
				clr_addr_q <= '0;
			end else if (clr_q) begin
				if (clr_addr_q == LAST_ADDR) begin
					clr_q <= 1'b0;
				end
				clr_addr_q <= clr_addr_q + ADDR_W'(1);
			end

			done_q <= accept_clr | v_s5;
			if (accept_clr) begin
				count_q   <= '0;
				new_bin_q <= 1'b0;
				occ_q     <= '0;
			end else if (v_s5) begin
				count_q   <= count_nxt;
				new_bin_q <= is_new;
				occ_q     <= count_nxt;
			end
		end
	end

	assign done           = done_q;
	assign new_bin        = new_bin_q;
	assign occupied_count = occ_q;

	// at most one pose stage or the sweep is active at once
	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({v_s1, v_s2, v_s3, v_s4, v_s5, clr_q}))
		else $error("more than one item in flight");

	// a pose transfer yields its strobe once it has passed the pipeline stages and the result register
	a_pose_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && kind == KIND_ADD) |-> ##6 done)
		else $error("pose result missing");

	// a clear transfer yields a zero result in the next cycle
	a_clear_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && kind == KIND_CLEAR) |=> (done && !new_bin && occupied_count == '0))
		else $error("clear result wrong");

	// a newly marked bin raises the count by one unless saturated
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s5 && is_new && count_q != COUNT_MAX) |=> (occupied_count == $past(count_q) + 1'b1))
		else $error("count did not step");

endmodule

// ===== tb/pose_bin_occupancy_counter_test.sv =====
// self-checking testbench for the pose bin occupancy counter
module pose_bin_occupancy_counter_test;
	timeunit 1ns;
	timeprecision 1ps;

	import pboc_pkg::*;

	// kinds of entry in the command queue: a pose or clear transfer, or a register write
	typedef enum logic {ENTRY_POSE, ENTRY_REG} entry_t;

	typedef struct packed {
		entry_t                  what;
		logic                    kind;
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
		logic [HEAD_W-1:0]       heading;
		logic [6:0]              idle_pct;
		logic                    drain;
		logic [CFG_IDX_W-1:0]    reg_idx;
		logic [CFG_DATA_W-1:0]   reg_data;
	} command_t;

	typedef struct packed {
		logic               new_bin;
		logic [COUNT_W-1:0] count;
	} tally_t;

	// dut ports, all inputs known from time zero
	logic                    clk;
	logic                    arst_n    = 1'b0;
	logic                    cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]    cfg_index = '0;
	logic [CFG_DATA_W-1:0]   cfg_data  = '0;
	logic                    start     = 1'b0;
	logic                    kind      = KIND_ADD;
	logic signed [POS_W-1:0] x_pos     = '0;
	logic signed [POS_W-1:0] y_pos     = '0;
	logic [HEAD_W-1:0]       heading   = '0;
	logic                    busy;
	logic                    done;
	logic                    new_bin;
	logic [COUNT_W-1:0]      occupied_count;

	pose_bin_occupancy_counter dut (.*);

	// 2 ns clock
	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// stimulus waiting to go out, and the tallies the block owes us
	command_t command_queue[$];
	tally_t   expected_tallies[$];

	bit          failed      = 1'b0;
	bit          item_taken  = 1'b0;
	int unsigned cycles      = 0;
	int unsigned cycle_limit = 32'hFFFF_FFFF;

	// predictor copy of the registers, starting at their reset values
	int                pred_xo = 0;
	int                pred_yo = 0;
	logic [HEAD_W-1:0] pred_ho = '0;
	int                pred_xu = int'(CELLS_RESET);
	int                pred_yu = int'(CELLS_RESET);

	// predictor copy of the bitmap and the running count
	bit                 bins_marked[int];
	logic [COUNT_W-1:0] bins_counted = '0;

	// generator view of the registers, so poses can be aimed at the grid
	int                gen_xo = 0;
	int                gen_yo = 0;
	logic [HEAD_W-1:0] gen_ho = '0;
	int                gen_xu = int'(CELLS_RESET);
	int                gen_yu = int'(CELLS_RESET);
	int                gen_idle = 35;
	int                n_pose = 0;
	int                n_clear = 0;
	int                n_reg = 0;

	// floor cell index along one axis; false when the pose falls off the grid
	function automatic bit cell_of(int pos, int origin, int used, output int idx);
		int d;
		d   = pos - origin;
		idx = 0;
		if (d < 0)
			return 1'b0;
		idx = d / DEF_POS_CELL_MM;
		return idx < used;
	endfunction

	// quantize one pose into its bin, mark it and give back the tally the block should report
	function automatic tally_t mark_pose(logic k, logic signed [POS_W-1:0] xp,
			logic signed [POS_W-1:0] yp, logic [HEAD_W-1:0] hd);
		tally_t            t;
		int                xi;
		int                yi;
		int                hi;
		int                bin;
		int                xu;
		int                yu;
		logic [HEAD_W-1:0] dh;
		t.new_bin = 1'b0;
		// cells in use saturate at the grid size
		xu = pred_xu > DEF_MAX_X_CELLS ? DEF_MAX_X_CELLS : pred_xu;
		yu = pred_yu > DEF_MAX_Y_CELLS ? DEF_MAX_Y_CELLS : pred_yu;
		if (k == KIND_CLEAR) begin
			bins_marked.delete();
			bins_counted = '0;
		end else if (cell_of(xp, pred_xo, xu, xi) && cell_of(yp, pred_yo, yu, yi)) begin
			// heading offset wraps round a full turn
			dh  = hd - pred_ho;
			hi  = (int'(dh) * DEF_HEADING_CELLS) >> HEAD_W;
			// strides of the full grid, so a change of cells in use never remaps a bin
			bin = (xi * DEF_MAX_Y_CELLS + yi) * DEF_HEADING_CELLS + hi;
			if (!bins_marked.exists(bin)) begin
				bins_marked[bin] = 1'b1;
				if (bins_counted != COUNT_MAX)
					bins_counted++;
				t.new_bin = 1'b1;
			end
		end
		t.count = bins_counted;
		return t;
	endfunction

	// queue one pose or clear, clamping positions into the 16-bit range
	task automatic queue_pose(logic k, int px, int py, logic [HEAD_W-1:0] hd, logic hold);
		command_t c;
		c          = '0;
		c.what     = ENTRY_POSE;
		c.kind     = k;
		c.x        = px > 32767 ? 16'sd32767 : (px < -32768 ? -16'sd32768 : px[POS_W-1:0]);
		c.y        = py > 32767 ? 16'sd32767 : (py < -32768 ? -16'sd32768 : py[POS_W-1:0]);
		c.heading  = hd;
		c.idle_pct = gen_idle[6:0];
		c.drain    = hold;
		command_queue = {command_queue, c};
		if (k == KIND_CLEAR)
			n_clear++;
		else
			n_pose++;
	endtask

	// queue one register write and track it for aiming later poses
	task automatic queue_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		command_t c;
		c          = '0;
		c.what     = ENTRY_REG;
		c.reg_idx  = idx;
		c.reg_data = data;
		command_queue = {command_queue, c};
		n_reg++;
		case (idx)
			REG_X_ORIGIN:       gen_xo = int'($signed(data));
			REG_Y_ORIGIN:       gen_yo = int'($signed(data));
			REG_HEADING_ORIGIN: gen_ho = data;
			REG_X_CELLS_USED:   gen_xu = int'(data[CELLS_W-1:0]);
			REG_Y_CELLS_USED:   gen_yu = int'(data[CELLS_W-1:0]);
			default: ;
		endcase
	endtask

	// driver: changes inputs at the falling edge, one nonblocking write per signal
	always @(negedge clk) begin : feed
		command_t head;
		logic     n_start;
		logic     n_we;
		// a presented item stays up until its transfer
		n_start = start && !item_taken;
		n_we    = 1'b0;
		item_taken = 1'b0;
		if (arst_n && !n_start && command_queue.size() != 0) begin
			head = command_queue[0];
			if (head.what == ENTRY_REG) begin
				// register writes only once the block is idle and owes nothing
				if (!busy && expected_tallies.size() == 0) begin
					n_we = 1'b1;
					cfg_index <= head.reg_idx;
					cfg_data  <= head.reg_data;
					void'(command_queue.pop_front());
				end
			end else if (head.drain && (busy || expected_tallies.size() != 0)) begin
				// hold back until every owed tally has come
			end else if ($urandom_range(99) >= int'(head.idle_pct)) begin
				n_start = 1'b1;
				kind    <= head.kind;
				x_pos   <= head.x;
				y_pos   <= head.y;
				heading <= head.heading;
				void'(command_queue.pop_front());
			end
		end
		start  <= n_start;
		cfg_we <= n_we;
	end

	// monitor: samples at the rising edge, checks results and predicts each transfer
	always @(posedge clk) begin : observe
		tally_t want;
		if (arst_n) begin
			// oldest tally first, before a transfer at this same edge adds one
			if (done) begin
				if (expected_tallies.size() == 0) begin
					$error("result strobe with no transfer waiting");
					failed = 1'b1;
				end else begin
					want = expected_tallies.pop_front();
					if (new_bin !== want.new_bin) begin
						$error("new_bin: expected %0d, got %0d", want.new_bin, new_bin);
						failed = 1'b1;
					end
					if (occupied_count !== want.count) begin
						$error("occupied_count: expected %0d, got %0d", want.count,
							occupied_count);
						failed = 1'b1;
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_X_ORIGIN:       pred_xo = int'($signed(cfg_data));
					REG_Y_ORIGIN:       pred_yo = int'($signed(cfg_data));
					REG_HEADING_ORIGIN: pred_ho = cfg_data;
					REG_X_CELLS_USED:   pred_xu = int'(cfg_data[CELLS_W-1:0]);
					REG_Y_CELLS_USED:   pred_yu = int'(cfg_data[CELLS_W-1:0]);
					default: ;
				endcase
			end
			if (start && !busy) begin
				expected_tallies = {expected_tallies, mark_pose(kind, x_pos, y_pos, heading)};
				item_taken = 1'b1;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= cycle_limit) begin
			$display("[pose_bin_occupancy_counter] ERROR");
			$finish;
		end
	end

	initial begin : run
		int                ph;
		int                i;
		int                r;
		int                ue_x;
		int                ue_y;
		int                hot_x;
		int                hot_y;
		int                px;
		int                py;
		logic [HEAD_W-1:0] hd;

		// directed: reset values of the registers, first bin, repeat, far corner
		queue_pose(KIND_ADD, 0, 0, 16'h0000, 1'b0);
		queue_pose(KIND_ADD, 0, 0, 16'h0000, 1'b0);
		queue_pose(KIND_ADD, 6399, 6399, 16'hFFFF, 1'b0);
		// just off the grid on each side
		queue_pose(KIND_ADD, 6400, 0, 16'h0000, 1'b0);
		queue_pose(KIND_ADD, 0, 6400, 16'h0000, 1'b0);
		queue_pose(KIND_ADD, -1, 0, 16'h0000, 1'b0);
		queue_pose(KIND_ADD, 0, -1, 16'h0000, 1'b0);
		queue_pose(KIND_ADD, -32768, 32767, 16'h0000, 1'b0);
		queue_pose(KIND_ADD, 32767, -32768, 16'h0000, 1'b0);
		// top of a cell and of a heading slot, then the next slot
		queue_pose(KIND_ADD, 99, 99, 16'd1820, 1'b0);
		queue_pose(KIND_ADD, 100, 0, 16'd1821, 1'b0);
		queue_pose(KIND_ADD, 0, 0, 16'h8000, 1'b1);
		// clear with its position fields at the extremes
		queue_pose(KIND_CLEAR, 32767, -32768, 16'hFFFF, 1'b0);
		queue_pose(KIND_ADD, 0, 0, 16'h0000, 1'b0);

		// directed: extreme origins, zero cells in use ignores everything
		queue_reg(REG_X_ORIGIN, 16'h8000);
		queue_reg(REG_Y_ORIGIN, 16'h7FFF);
		queue_reg(REG_HEADING_ORIGIN, 16'hFFFF);
		queue_reg(REG_X_CELLS_USED, 16'd0);
		queue_reg(REG_Y_CELLS_USED, 16'd1);
		queue_pose(KIND_ADD, -32768, 32767, 16'hFFFF, 1'b0);
		// cells above the grid saturate; old bins keep their place
		queue_reg(REG_X_CELLS_USED, 16'd127);
		queue_pose(KIND_ADD, -32768, 32767, 16'hFFFF, 1'b0);
		queue_pose(KIND_ADD, -26369, 32767, 16'hFFFE, 1'b0);
		queue_pose(KIND_ADD, -26368, 32767, 16'h0000, 1'b0);
		queue_pose(KIND_ADD, -32768, 32766, 16'h0000, 1'b0);
		queue_pose(KIND_ADD, 32767, 32767, 16'h0000, 1'b0);
		queue_reg(REG_Y_CELLS_USED, 16'd0);
		queue_pose(KIND_ADD, -32768, 32767, 16'h0000, 1'b0);
		queue_reg(REG_Y_CELLS_USED, 16'd65);
		queue_reg(REG_X_CELLS_USED, 16'd1);
		queue_pose(KIND_ADD, -32669, 32767, 16'h8000, 1'b0);
		queue_pose(KIND_ADD, -32668, 32767, 16'h8000, 1'b0);
		queue_pose(KIND_CLEAR, 0, 0, 16'h0000, 1'b0);

		// random phases: sender idles 35 %, then 68 %, then not at all
		for (ph = 0; ph < 12; ph++) begin
			gen_idle = ph < 4 ? 35 : (ph < 8 ? 68 : 0);
			// origins that keep the whole grid inside the 16-bit range
			queue_reg(REG_X_ORIGIN, 16'($urandom_range(0, 59135) - 32768));
			queue_reg(REG_Y_ORIGIN, 16'($urandom_range(0, 59135) - 32768));
			queue_reg(REG_HEADING_ORIGIN, 16'($urandom_range(65535)));
			case (ph % 6)
				0: begin
					queue_reg(REG_HEADING_ORIGIN, 16'h0000);
					queue_reg(REG_X_CELLS_USED, 16'd64);
					queue_reg(REG_Y_CELLS_USED, 16'd64);
				end
				1: begin
					queue_reg(REG_X_CELLS_USED, 16'd1);
					queue_reg(REG_Y_CELLS_USED, 16'd1);
				end
				3: begin
					queue_reg(REG_X_CELLS_USED, 16'd127);
					queue_reg(REG_Y_CELLS_USED, 16'($urandom_range(1, 64)));
				end
				4: begin
					// origins at the very ends, part of the grid beyond reach
					queue_reg(REG_X_ORIGIN, 16'h8000);
					queue_reg(REG_Y_ORIGIN, 16'(32767 - 999));
					queue_reg(REG_HEADING_ORIGIN, 16'hFFFF);
					queue_reg(REG_X_CELLS_USED, 16'($urandom_range(1, 64)));
					queue_reg(REG_Y_CELLS_USED, 16'($urandom_range(1, 64)));
				end
				5: begin
					queue_reg(REG_X_CELLS_USED, 16'($urandom_range(65, 127)));
					queue_reg(REG_Y_CELLS_USED, 16'($urandom_range(65, 127)));
				end
				default: begin
					queue_reg(REG_X_CELLS_USED, 16'($urandom_range(1, 64)));
					queue_reg(REG_Y_CELLS_USED, 16'($urandom_range(1, 64)));
				end
			endcase
			ue_x  = gen_xu > DEF_MAX_X_CELLS ? DEF_MAX_X_CELLS : (gen_xu == 0 ? 1 : gen_xu);
			ue_y  = gen_yu > DEF_MAX_Y_CELLS ? DEF_MAX_Y_CELLS : (gen_yu == 0 ? 1 : gen_yu);
			hot_x = ue_x < 4 ? ue_x : 4;
			hot_y = ue_y < 4 ? ue_y : 4;
			for (i = 0; i < 158; i++) begin
				r = $urandom_range(99);
				if (r < 2) begin
					// clear with random leftovers in the position fields
					queue_pose(KIND_CLEAR, $urandom_range(65535) - 32768,
						$urandom_range(65535) - 32768, 16'($urandom_range(65535)), 1'b0);
				end else if (r < 55) begin
					// a few hot bins near the origin, so repeats are common
					px = gen_xo + $urandom_range(0, hot_x - 1) * DEF_POS_CELL_MM
						+ $urandom_range(0, DEF_POS_CELL_MM - 1);
					py = gen_yo + $urandom_range(0, hot_y - 1) * DEF_POS_CELL_MM
						+ $urandom_range(0, DEF_POS_CELL_MM - 1);
					hd = gen_ho + 16'($urandom_range(0, 5) * 1821);
					queue_pose(KIND_ADD, px, py, hd, i % 150 == 75);
				end else if (r < 82) begin
					// anywhere on the grid in use
					px = gen_xo + $urandom_range(0, ue_x * DEF_POS_CELL_MM - 1);
					py = gen_yo + $urandom_range(0, ue_y * DEF_POS_CELL_MM - 1);
					queue_pose(KIND_ADD, px, py, 16'($urandom_range(65535)), 1'b0);
				end else if (r < 92) begin
					// grid edges and heading wrap
					case ($urandom_range(3))
						0: px = gen_xo - 1;
						1: px = gen_xo;
						2: px = gen_xo + ue_x * DEF_POS_CELL_MM - 1;
						default: px = gen_xo + ue_x * DEF_POS_CELL_MM;
					endcase
					case ($urandom_range(3))
						0: py = gen_yo - 1;
						1: py = gen_yo;
						2: py = gen_yo + ue_y * DEF_POS_CELL_MM - 1;
						default: py = gen_yo + ue_y * DEF_POS_CELL_MM;
					endcase
					case ($urandom_range(2))
						0: hd = gen_ho - 16'd1;
						1: hd = gen_ho;
						default: hd = 16'($urandom_range(65535));
					endcase
					queue_pose(KIND_ADD, px, py, hd, 1'b0);
				end else begin
					// noise over the whole field range
					queue_pose(KIND_ADD, $urandom_range(65535) - 32768,
						$urandom_range(65535) - 32768, 16'($urandom_range(65535)), 1'b0);
				end
			end
		end

		// each clear and the reset sweep walk the whole bitmap; poses take their pipeline pass plus gaps
		cycle_limit = 4 * (n_clear * 4700 + n_pose * 40 + n_reg * 10 + 4700 + 1000);

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// drain, then a short tail in case a stray strobe follows
		do
			@(posedge clk);
		while (command_queue.size() != 0 || start || expected_tallies.size() != 0);
		repeat (32) @(posedge clk);
		@(negedge clk);

		if (!failed && expected_tallies.size() == 0)
			$display("[pose_bin_occupancy_counter] OK");
		else
			$display("[pose_bin_occupancy_counter] ERROR");
		$finish;
	end

endmodule

// ===== pose_bin_occupancy_counter.f =====
design/pboc_pkg.sv
design/pose_bin_occupancy_counter.sv
tb/pose_bin_occupancy_counter_test.sv
